// ===== sv/touch_contact_slot_tracker_core_defines.svh =====
// Assertion macros shared by the slot tracker RTL.
`ifndef TOUCH_CONTACT_SLOT_TRACKER_CORE_DEFINES_SVH
`define TOUCH_CONTACT_SLOT_TRACKER_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define TCST_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define TCST_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define TCST_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define TCST_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

// ===== sv/tcst_pkg.sv =====
`default_nettype none

package tcst_pkg;

   localparam logic signed [31:0] OP_PRESS   = 32'sd2;
   localparam logic signed [31:0] OP_RELEASE = 32'sd3;

   // word position of the pressure word, the last of a press
   localparam logic [2:0] PRESS_LAST_POS = 3'd5;
   localparam logic [2:0] POS_OPCODE     = 3'd0;
   localparam logic [2:0] POS_FIRST_OPND = 3'd1;

   typedef enum logic [1:0] {
      K_NONE    = 2'd0,
      K_PRESS   = 2'd1,
      K_RELEASE = 2'd2,
      K_UNKNOWN = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      ST_INSERTED = 3'd0,
      ST_UPDATED  = 3'd1,
      ST_RELEASED = 3'd2,
      ST_ABSENT   = 3'd3,
      ST_FULL     = 3'd4,
      ST_UNKNOWN  = 3'd5
   } status_type;

   // command handed to the slot table
   typedef struct packed {
      logic        start;
      logic        is_press;
      logic        barre;
      logic [31:0] node;
      logic [31:0] contact;
      logic [31:0] stretch;
      logic [31:0] pressure;
   } cmd_type;

   // table outcome, done pulses for one cycle
   typedef struct packed {
      logic       done;
      status_type status;
      logic [4:0] slot;
   } res_type;

endpackage

`default_nettype wire

// ===== sv/tcst_if.sv =====
`default_nettype none

// command word channel
interface tcst_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] word;

   modport source (output valid, output word, input ready);
   modport sink   (input valid, input word, output ready);
endinterface

// status channel
interface tcst_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] status;
   logic [4:0] slot;
   logic [4:0] occupied;

   modport source (output valid, output status, output slot, output occupied, input ready);
   modport sink   (input valid, input status, input slot, input occupied, output ready);
endinterface

`default_nettype wire

// ===== sv/touch_contact_slot_tracker_core.sv =====
// Channel  Dir  Beat                   Accept
// req_bus  in   one 32-bit word        valid && ready
// rsp_bus  out  status, slot, occupied valid && ready
//
// A press takes 6 word beats, at most one per cycle, then ready stays low
// through launch, one slot compare per cycle on a single comparator, drain,
// resolve and the status load. A release takes 2 beats and then the same
// steps. An unknown opcode takes 2 beats; ready stays low until launch, which
// loads the status register directly, without a table scan.
// Reset is synchronous and clears the parser, the valid bits and the count.
// req_bus.ready drops from the last word of a command until its status is
// loaded; a status still waiting on rsp_bus holds the next command's launch.
`default_nettype none
`include "touch_contact_slot_tracker_core_defines.svh"

module touch_contact_slot_tracker_core #(
   parameter int SLOTS = 20
) (
   input wire logic    clock,
   input wire logic    reset,
   tcst_req_if.sink    req_bus,
   tcst_rsp_if.source  rsp_bus
);

   typedef enum logic [1:0] {
      S_PARSE,   // taking words
      S_PEND,    // command complete, waiting for the status register
      S_SCAN     // table busy
   } state_type;

   state_type          state_ff;
   logic [2:0]         pos_ff;
   tcst_pkg::kind_type kind_ff;
   logic               held_barre_ff;
   logic [31:0]        held_node_ff;
   logic [31:0]        held_contact_ff;
   logic [31:0]        held_stretch_ff;
   logic [31:0]        held_pressure_ff;

   logic       rsp_valid_ff;
   logic [2:0] rsp_status_ff;
   logic [4:0] rsp_slot_ff;
   logic [4:0] rsp_occ_ff;

   tcst_pkg::cmd_type tbl_cmd;
   tcst_pkg::res_type tbl_res;
   logic [4:0]        tbl_occ;
   logic              req_beat;
   logic              launch;

   assign req_bus.ready = (state_ff == S_PARSE);
   assign req_beat      = req_bus.valid && (state_ff == S_PARSE);

   // the status register must be empty before anything reports into it
   assign launch = (state_ff == S_PEND) && !rsp_valid_ff;

   always_comb begin
      tbl_cmd.start    = launch && (kind_ff != tcst_pkg::K_UNKNOWN);
      tbl_cmd.is_press = (kind_ff == tcst_pkg::K_PRESS);
      tbl_cmd.barre    = held_barre_ff;
      tbl_cmd.node     = held_node_ff;
      tbl_cmd.contact  = held_contact_ff;
      tbl_cmd.stretch  = held_stretch_ff;
      tbl_cmd.pressure = held_pressure_ff;
   end

   tcst_slot_table #(
      .SLOTS (SLOTS)
   ) u_table (
      .clock    (clock),
      .reset    (reset),
      .cmd      (tbl_cmd),
      .res      (tbl_res),
      .occupied (tbl_occ)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_PARSE;
         pos_ff       <= tcst_pkg::POS_OPCODE;
         kind_ff      <= tcst_pkg::K_NONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            S_PARSE: begin
               if (req_beat) begin
                  if (pos_ff == tcst_pkg::POS_OPCODE) begin
                     // decode opcode word
                     if (req_bus.word == tcst_pkg::OP_PRESS) begin
                        kind_ff <= tcst_pkg::K_PRESS;
                     end else if (req_bus.word == tcst_pkg::OP_RELEASE) begin
                        kind_ff <= tcst_pkg::K_RELEASE;
                     end else begin
                        kind_ff <= tcst_pkg::K_UNKNOWN;
                     end
                     pos_ff <= tcst_pkg::POS_FIRST_OPND;
                  end else if (kind_ff == tcst_pkg::K_PRESS) begin
                     case (pos_ff)
                        3'd1: held_barre_ff   <= (req_bus.word != 32'sd0);
                        3'd2: held_node_ff    <= req_bus.word;
                        3'd3: held_contact_ff <= req_bus.word;
                        3'd4: held_stretch_ff <= req_bus.word;
                        default: held_pressure_ff <= req_bus.word;
                     endcase
                     if (pos_ff == tcst_pkg::PRESS_LAST_POS) begin
                        pos_ff   <= tcst_pkg::POS_OPCODE;
                        state_ff <= S_PEND;
                     end else begin
                        pos_ff <= pos_ff + 3'd1;
                     end
                  end else begin
                     // release id, or the ignored word of an unknown opcode
                     held_contact_ff <= req_bus.word;
                     pos_ff          <= tcst_pkg::POS_OPCODE;
                     state_ff        <= S_PEND;
                  end
               end
            end
            S_PEND: begin
               if (launch) begin
                  if (kind_ff == tcst_pkg::K_UNKNOWN) begin
                     rsp_valid_ff  <= 1'b1;
                     rsp_status_ff <= tcst_pkg::ST_UNKNOWN;
                     rsp_slot_ff   <= 5'd0;
                     rsp_occ_ff    <= tbl_occ;
                     kind_ff       <= tcst_pkg::K_NONE;
                     state_ff      <= S_PARSE;
                  end else begin
                     state_ff <= S_SCAN;
                  end
               end
            end
            S_SCAN: begin
               if (tbl_res.done) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= tbl_res.status;
                  rsp_slot_ff   <= tbl_res.slot;
                  rsp_occ_ff    <= tbl_occ;
                  kind_ff       <= tcst_pkg::K_NONE;
                  state_ff      <= S_PARSE;
               end
            end
            default: begin
               state_ff <= S_PARSE;
            end
         endcase
      end
   end

   assign rsp_bus.valid    = rsp_valid_ff;
   assign rsp_bus.status   = rsp_status_ff;
   assign rsp_bus.slot     = rsp_slot_ff;
   assign rsp_bus.occupied = rsp_occ_ff;

   `TCST_ASSERT_IMP(a_done_in_scan, clock, reset, tbl_res.done, state_ff == S_SCAN, "stray done")
   `TCST_ASSERT_IMP(a_done_reg_free, clock, reset, tbl_res.done, !rsp_valid_ff, "status reg full")
   `TCST_ASSERT_NEXT(a_start_scan, clock, reset, tbl_cmd.start, state_ff == S_SCAN, "no scan")

endmodule

`default_nettype wire

// ===== sv/tcst_slot_table.sv =====
`default_nettype none
`include "touch_contact_slot_tracker_core_defines.svh"

// Slot table: valid bits in flops, contact ids and slot data in memories.
// One comparator walks the slots, one per cycle, to find the first hit
// and the first free slot; the update is applied in a resolve cycle.
module tcst_slot_table #(
   parameter int SLOTS = 20
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire tcst_pkg::cmd_type cmd,
   output tcst_pkg::res_type     res,
   output logic [4:0]            occupied
);

   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W = $clog2(SLOTS + 1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

   typedef enum logic [1:0] {
      T_IDLE,
      T_SCAN,
      T_DRAIN,
      T_RESOLVE
   } state_type;

   typedef struct packed {
      logic        barre;
      logic [31:0] node;
      logic [31:0] stretch;
      logic [31:0] pressure;
   } record_type;

   state_type         state_ff;
   tcst_pkg::cmd_type cmd_ff;
   tcst_pkg::res_type res_ff;
   logic [SLOTS-1:0]  valid_ff;
   logic [CNT_W-1:0]  occ_ff;
   logic [IDX_W-1:0]  idx_ff;
   logic [IDX_W-1:0]  cmp_idx_ff;
   logic              cmp_vld_ff;
   logic              hit_ff;
   logic [IDX_W-1:0]  hit_idx_ff;
   logic              free_ff;
   logic [IDX_W-1:0]  free_idx_ff;
   logic [31:0]       rd_contact_ff;

   logic [31:0] contact_mem [SLOTS];
   record_type  rec_mem [SLOTS];

   logic                 hit_now;
   logic                 free_now;
   logic                 wr_en;
   logic                 set_valid;
   logic                 clr_valid;
   logic [IDX_W-1:0]     tgt_idx;
   tcst_pkg::status_type status_in;
   logic [4:0]           slot_in;
   logic [CNT_W-1:0]     occ_in;

   // the shared compare unit
   assign hit_now  = valid_ff[cmp_idx_ff] && (rd_contact_ff == cmd_ff.contact);
   assign free_now = !valid_ff[cmp_idx_ff];

   always_comb begin
      wr_en     = 1'b0;
      set_valid = 1'b0;
      clr_valid = 1'b0;
      tgt_idx   = hit_idx_ff;
      status_in = tcst_pkg::ST_ABSENT;
      slot_in   = 5'd0;
      occ_in    = occ_ff;
      if (cmd_ff.is_press) begin
         if (hit_ff) begin
            wr_en     = 1'b1;
            status_in = tcst_pkg::ST_UPDATED;
         end else if (free_ff) begin
            wr_en     = 1'b1;
            set_valid = 1'b1;
            tgt_idx   = free_idx_ff;
            status_in = tcst_pkg::ST_INSERTED;
            occ_in    = occ_ff + CNT_W'(1);
         end else begin
            status_in = tcst_pkg::ST_FULL;
         end
      end else if (hit_ff) begin
         clr_valid = 1'b1;
         status_in = tcst_pkg::ST_RELEASED;
         occ_in    = occ_ff - CNT_W'(1);
      end
      if (wr_en || clr_valid) begin
         slot_in = 5'(tgt_idx);
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff == T_RESOLVE) && wr_en) begin
         contact_mem[tgt_idx] <= cmd_ff.contact;
         rec_mem[tgt_idx]     <= '{barre:    cmd_ff.barre,
                                   node:     cmd_ff.node,
                                   stretch:  cmd_ff.stretch,
                                   pressure: cmd_ff.pressure};
      end
      rd_contact_ff <= contact_mem[idx_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= T_IDLE;
         valid_ff   <= '0;
         occ_ff     <= '0;
         cmp_vld_ff <= 1'b0;
         hit_ff     <= 1'b0;
         free_ff    <= 1'b0;
         res_ff     <= '0;
      end else begin
         // done pulses for the cycle after resolve
         res_ff.done <= (state_ff == T_RESOLVE);

         if (cmp_vld_ff) begin
            if (!hit_ff && hit_now) begin
               hit_ff     <= 1'b1;
               hit_idx_ff <= cmp_idx_ff;
            end
            if (!free_ff && free_now) begin
               free_ff     <= 1'b1;
               free_idx_ff <= cmp_idx_ff;
            end
         end

         case (state_ff)
            T_IDLE: begin
               if (cmd.start) begin
                  cmd_ff   <= cmd;
                  idx_ff   <= '0;
                  hit_ff   <= 1'b0;
                  free_ff  <= 1'b0;
                  state_ff <= T_SCAN;
               end
            end
            T_SCAN: begin
               cmp_vld_ff <= 1'b1;
               cmp_idx_ff <= idx_ff;
               if (idx_ff == LAST_IDX) begin
                  state_ff <= T_DRAIN;
               end else begin
                  idx_ff <= idx_ff + IDX_W'(1);
               end
            end
            T_DRAIN: begin
               cmp_vld_ff <= 1'b0;
               state_ff   <= T_RESOLVE;
            end
            T_RESOLVE: begin
               if (set_valid) begin
                  valid_ff[tgt_idx] <= 1'b1;
               end
               if (clr_valid) begin
                  valid_ff[tgt_idx] <= 1'b0;
               end
               occ_ff        <= occ_in;
               res_ff.status <= status_in;
               res_ff.slot   <= slot_in;
               state_ff      <= T_IDLE;
            end
            default: begin
               state_ff <= T_IDLE;
            end
         endcase
      end
   end

   assign res      = res_ff;
   assign occupied = 5'(occ_ff);

   `TCST_ASSERT_IMP(a_count_matches, clock, reset, 1'b1, 32'(occ_ff) == $countones(valid_ff), "count")
   `TCST_ASSERT_NEXT(a_resolve_done, clock, reset, state_ff == T_RESOLVE, res_ff.done, "no done")
   `TCST_ASSERT_IMP(a_drain_compares, clock, reset, state_ff == T_DRAIN, cmp_vld_ff, "no compare")

endmodule

`default_nettype wire
